// ===== rtl/core/ows_pkg.sv =====
// shared types, field widths and codes of the overlap write scoreboard
package ows_pkg;

  localparam int SLOTS_DEF       = 32;
  localparam int OFFSET_BITS_DEF = 48;

  localparam int OFFSET_W = 48;
  localparam int SIZE_W   = 21;
  localparam int SLOT_W   = 5;
  localparam int COUNT_W  = 5;
  localparam int KIND_W   = 3;
  localparam int ERR_W    = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MARKED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd4;

  localparam logic [ERR_W-1:0] ERR_FULL     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_SLOT = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BUSY     = 2'd2;

  typedef struct packed {
    logic                action;
    logic [OFFSET_W-1:0] write_offset;
    logic [SIZE_W-1:0]   write_size;
    logic [SLOT_W-1:0]   slot_id;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  entry_slot;
    logic [COUNT_W-1:0] overlap_count;
    logic               was_overwritten;
    logic [ERR_W-1:0]   error_code;
    logic               last;
  } res_t;

  typedef struct packed {
    logic overlap;
    logic covered;
  } cmp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_DONE,
    S_DEL_CHK,
    S_DEL_SCAN,
    S_DEL_DONE,
    S_ERR
  } state_t;

endpackage

// ===== rtl/core/ows_if.sv =====
// valid/ready channels for commands and results
interface ows_cmd_if;
  logic          valid;
  logic          ready;
  ows_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ows_res_if;
  logic          valid;
  logic          ready;
  ows_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ows_cmp.sv =====
// range compare of a stored entry against the reference write
module ows_cmp #(
  parameter int OFF_W = ows_pkg::OFFSET_BITS_DEF,
  parameter int END_W = ows_pkg::OFFSET_BITS_DEF + 1
) (
  input  logic [OFF_W-1:0] a_off,
  input  logic [END_W-1:0] a_lim,
  input  logic [OFF_W-1:0] b_off,
  input  logic [END_W-1:0] b_lim,
  output ows_pkg::cmp_t    result
);

  logic [END_W-1:0] a_off_x;
  logic [END_W-1:0] b_off_x;

  assign a_off_x = END_W'(a_off);
  assign b_off_x = END_W'(b_off);

  // half-open ranges, limits kept one bit wider so nothing wraps
  assign result.overlap = (a_off_x < b_lim) && (b_off_x < a_lim);
  assign result.covered = (b_off_x <= a_off_x) && (a_lim <= b_lim);

endmodule

// ===== rtl/core/overlap_write_scoreboard.sv =====
// overlap write scoreboard top level: slot table, scan sequencer and result register
//
//   channel | modport | payload            | accepted when
//   cmd     | sink    | ows_pkg::cmd_t     | cmd.valid && cmd.ready
//   res     | source  | ows_pkg::res_t     | res.valid && res.ready
//
// an insert or a good delete scans every slot through the entry memory, one slot a cycle
// unless a waiting result stalls it; a full table, a bad slot or a delete of a slot with
// a nonzero count gives an error result with no scan.
// the single read port of the entry memory sets the scan rate.
// reset clears the slot valid bits at once; the memory needs no clearing.
// a result waiting at res stalls the scan only when another result is due.
module overlap_write_scoreboard #(
  parameter int SLOTS       = ows_pkg::SLOTS_DEF,
  parameter int OFFSET_BITS = ows_pkg::OFFSET_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  ows_cmd_if.sink   cmd,
  ows_res_if.source res
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int OFF_W = (OFFSET_BITS < ows_pkg::OFFSET_W) ? OFFSET_BITS : ows_pkg::OFFSET_W;
  localparam int END_W = ((OFF_W > ows_pkg::SIZE_W) ? OFF_W : ows_pkg::SIZE_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef struct packed {
    logic [OFF_W-1:0]            off;
    logic [END_W-1:0]            lim;
    logic [ows_pkg::COUNT_W-1:0] count;
    logic                        ow;
  } entry_t;

  ows_pkg::state_t state;
  ows_pkg::state_t state_next;

  logic [SLOTS-1:0] valid;
  entry_t           mem [SLOTS];
  entry_t           rd_data;

  logic [OFF_W-1:0]            ref_off;
  logic [END_W-1:0]            ref_lim;
  logic [IDX_W-1:0]            new_slot;
  logic [ows_pkg::SLOT_W-1:0]  op_slot;
  logic [ows_pkg::ERR_W-1:0]   err_code;
  logic [ows_pkg::COUNT_W-1:0] cnt;
  ows_pkg::res_t               pend;

  logic [IDX_W-1:0] iss_idx;
  logic             iss_done;
  logic             ev_vld;
  logic [IDX_W-1:0] ev_idx;

  logic          res_valid_r;
  ows_pkg::res_t res_data_r;

  logic             cmd_ready;
  logic             accept;
  logic             out_free;
  logic [IDX_W-1:0] free_slot;
  logic             full;
  logic [IDX_W-1:0] sid_idx;
  logic             sid_ok;
  logic [IDX_W-1:0] op_idx;
  ows_pkg::cmp_t    cmp;

  logic ev_hit_ins;
  logic ev_cover;
  logic ev_hit_del;
  logic ev_release;

  logic             adv;
  logic             scan_start;
  logic             out_load;
  ows_pkg::res_t    out_item;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_ren;
  logic [IDX_W-1:0] mem_raddr;
  logic             set_valid;
  logic             clr_valid;

  assign cmd.ready = cmd_ready;
  assign res.valid = res_valid_r;
  assign res.data  = res_data_r;

  assign cmd_ready = (state == ows_pkg::S_IDLE);
  assign accept    = cmd.valid && cmd_ready;
  assign out_free  = !res_valid_r || res.ready;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = IDX_W'(i);
      end
    end
  end

  assign full    = &valid;
  assign sid_idx = IDX_W'(cmd.data.slot_id);
  assign sid_ok  = (32'(cmd.data.slot_id) < 32'(SLOTS)) && valid[sid_idx];
  assign op_idx  = IDX_W'(op_slot);

  ows_cmp #(
    .OFF_W (OFF_W),
    .END_W (END_W)
  ) u_cmp (
    .a_off  (rd_data.off),
    .a_lim  (rd_data.lim),
    .b_off  (ref_off),
    .b_lim  (ref_lim),
    .result (cmp)
  );

  assign ev_hit_ins = ev_vld && valid[ev_idx] && cmp.overlap;
  assign ev_cover   = ev_hit_ins && cmp.covered;
  assign ev_hit_del = ev_vld && valid[ev_idx] && cmp.overlap && (rd_data.count != '0);
  assign ev_release = ev_hit_del && (rd_data.count == ows_pkg::COUNT_ONE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ows_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd.data.action == ows_pkg::ACT_INSERT) begin
            state_next = full ? ows_pkg::S_ERR : ows_pkg::S_INS_SCAN;
          end else begin
            state_next = sid_ok ? ows_pkg::S_DEL_CHK : ows_pkg::S_ERR;
          end
        end
      end
      ows_pkg::S_INS_SCAN: begin
        if (adv && iss_done) begin
          state_next = ows_pkg::S_INS_DONE;
        end
      end
      ows_pkg::S_DEL_CHK: begin
        state_next = (rd_data.count != '0) ? ows_pkg::S_ERR : ows_pkg::S_DEL_SCAN;
      end
      ows_pkg::S_DEL_SCAN: begin
        if (adv && iss_done) begin
          state_next = ows_pkg::S_DEL_DONE;
        end
      end
      ows_pkg::S_INS_DONE, ows_pkg::S_DEL_DONE, ows_pkg::S_ERR: begin
        if (out_free) begin
          state_next = ows_pkg::S_IDLE;
        end
      end
      default: state_next = ows_pkg::S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    adv        = 1'b0;
    scan_start = 1'b0;
    out_load   = 1'b0;
    out_item   = '0;
    mem_we     = 1'b0;
    mem_waddr  = ev_idx;
    mem_wdata  = rd_data;
    mem_ren    = 1'b0;
    mem_raddr  = iss_idx;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    unique case (state)
      ows_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd.data.action == ows_pkg::ACT_INSERT) begin
            scan_start = !full;
          end else if (sid_ok) begin
            mem_ren   = 1'b1;
            mem_raddr = sid_idx;
          end
        end
      end
      ows_pkg::S_INS_SCAN: begin
        adv = !ev_cover || out_free;
        if (adv) begin
          mem_ren = !iss_done;
          if (ev_cover) begin
            mem_we              = 1'b1;
            mem_wdata.ow        = 1'b1;
            out_load            = 1'b1;
            out_item.kind       = ows_pkg::KIND_MARKED;
            out_item.entry_slot = ows_pkg::SLOT_W'(ev_idx);
          end
        end
      end
      ows_pkg::S_INS_DONE: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_item.kind          = ows_pkg::KIND_INSERTED;
          out_item.entry_slot    = ows_pkg::SLOT_W'(new_slot);
          out_item.overlap_count = cnt;
          out_item.last          = 1'b1;
          mem_we                 = 1'b1;
          mem_waddr              = new_slot;
          mem_wdata.off          = ref_off;
          mem_wdata.lim          = ref_lim;
          mem_wdata.count        = cnt;
          mem_wdata.ow           = 1'b0;
          set_valid              = 1'b1;
        end
      end
      ows_pkg::S_DEL_CHK: begin
        if (rd_data.count == '0) begin
          clr_valid  = 1'b1;
          scan_start = 1'b1;
        end
      end
      ows_pkg::S_DEL_SCAN: begin
        // the held result goes out only once the next one is known
        adv = !ev_release || out_free;
        if (adv) begin
          mem_ren = !iss_done;
          if (ev_hit_del) begin
            mem_we          = 1'b1;
            mem_wdata.count = rd_data.count - ows_pkg::COUNT_ONE;
          end
          if (ev_release) begin
            out_load = 1'b1;
            out_item = pend;
          end
        end
      end
      ows_pkg::S_DEL_DONE: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_item      = pend;
          out_item.last = 1'b1;
        end
      end
      ows_pkg::S_ERR: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_item.kind       = ows_pkg::KIND_ERROR;
          out_item.entry_slot = op_slot;
          out_item.error_code = err_code;
          out_item.last       = 1'b1;
        end
      end
      default: begin
        adv = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ows_pkg::S_IDLE;
      valid       <= '0;
      ev_vld      <= 1'b0;
      iss_done    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state <= state_next;
      if (set_valid) begin
        valid[new_slot] <= 1'b1;
      end
      if (clr_valid) begin
        valid[op_idx] <= 1'b0;
      end
      if (scan_start) begin
        ev_vld   <= 1'b0;
        iss_done <= 1'b0;
      end else if (adv) begin
        ev_vld <= !iss_done;
        if (mem_ren) begin
          iss_done <= (iss_idx == LAST_IDX);
        end
      end
      if (out_load) begin
        res_valid_r <= 1'b1;
      end else if (res.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_ren) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      res_data_r <= out_item;
    end
    if (accept) begin
      ref_off  <= cmd.data.write_offset[OFF_W-1:0];
      ref_lim  <= END_W'(cmd.data.write_offset[OFF_W-1:0]) + END_W'(cmd.data.write_size);
      new_slot <= free_slot;
      cnt      <= '0;
      if (cmd.data.action == ows_pkg::ACT_INSERT) begin
        op_slot  <= '0;
        err_code <= ows_pkg::ERR_FULL;
      end else begin
        op_slot  <= cmd.data.slot_id;
        err_code <= ows_pkg::ERR_BAD_SLOT;
      end
    end
    if (state == ows_pkg::S_DEL_CHK) begin
      ref_off  <= rd_data.off;
      ref_lim  <= rd_data.lim;
      err_code <= ows_pkg::ERR_BUSY;
      pend     <= '{kind: ows_pkg::KIND_DELETED, entry_slot: op_slot,
                    overlap_count: '0, was_overwritten: 1'b0,
                    error_code: '0, last: 1'b0};
    end
    if (scan_start) begin
      iss_idx <= '0;
    end else if (adv && mem_ren) begin
      iss_idx <= iss_idx + IDX_W'(1);
    end
    if (adv) begin
      ev_idx <= iss_idx;
    end
    if (state == ows_pkg::S_INS_SCAN && adv && ev_hit_ins && cnt != ows_pkg::COUNT_MAX) begin
      cnt <= cnt + ows_pkg::COUNT_ONE;
    end
    if (state == ows_pkg::S_DEL_SCAN && adv && ev_release) begin
      pend <= '{kind: ows_pkg::KIND_RELEASED, entry_slot: ows_pkg::SLOT_W'(ev_idx),
                overlap_count: '0, was_overwritten: rd_data.ow,
                error_code: '0, last: 1'b0};
    end
  end

`ifndef ASSERT_OFF
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_ren) |-> (mem_waddr != mem_raddr))
    else $error("entry memory read and write hit the same slot");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_item.last) |=> (state == ows_pkg::S_IDLE))
    else $error("final result issued but sequencer not idle");

  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    set_valid |-> !valid[new_slot])
    else $error("insert into a slot already in use");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result register overwritten while waiting");
`endif

endmodule
